@@ sv/fmdp_pkg.sv @@
// shared constants, types and codes of the fm datagram parser
package fmdp_pkg;

   localparam int MAX_SAMPLES    = 256;
   localparam int CALLSIGN_BOUND = 16;
   localparam int FIFO_DEPTH     = 4;

   localparam int SMP_CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int CHAR_CNT_W = $clog2(CALLSIGN_BOUND);
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int SMP_TOT_W  = 9;
   localparam int CHAR_TOT_W = 4;

   localparam logic [7:0] CHAR_F   = 8'h46;
   localparam logic [7:0] CHAR_M   = 8'h4D;
   localparam logic [7:0] CHAR_P   = 8'h50;
   localparam logic [7:0] CHAR_E   = 8'h45;
   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_D   = 8'h44;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic [1:0] {
      PHASE_TAG0    = 2'd0,
      PHASE_TAG1    = 2'd1,
      PHASE_TAG2    = 2'd2,
      PHASE_PAYLOAD = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      PKT_NONE  = 3'd0,
      PKT_PING  = 3'd1,
      PKT_END   = 3'd2,
      PKT_START = 3'd3,
      PKT_DATA  = 3'd4
   } pkt_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_SAMPLE  = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                result_kind;
      logic [7:0]              char_value;
      logic signed [15:0]      audio_sample;
      pkt_type                 packet_type;
      logic                    malformed;
      logic [SMP_TOT_W-1:0]    sample_total;
      logic [CHAR_TOT_W-1:0]   callsign_total;
      logic                    run_last;
   } result_type;

   localparam result_type RESULT_ZERO = '{
      result_kind:    KIND_CHAR,
      char_value:     8'd0,
      audio_sample:   16'sd0,
      packet_type:    PKT_NONE,
      malformed:      1'b0,
      sample_total:   '0,
      callsign_total: '0,
      run_last:       1'b0
   };

endpackage

@@ sv/fmdp_ifs.sv @@
// byte request and result channel interfaces of the fm datagram parser
interface fmdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fmdp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [7:0]         char_value;
   logic signed [15:0] audio_sample;
   logic [2:0]         packet_type;
   logic               malformed;
   logic [8:0]         sample_total;
   logic [3:0]         callsign_total;
   logic               run_last;

   modport source (output valid, output result_kind, output char_value,
                   output audio_sample, output packet_type, output malformed,
                   output sample_total, output callsign_total, output run_last,
                   input ready);
   modport sink   (input valid, input result_kind, input char_value,
                   input audio_sample, input packet_type, input malformed,
                   input sample_total, input callsign_total, input run_last,
                   output ready);
endinterface

@@ sv/fm_datagram_parser.sv @@
// top level of the fm datagram parser: tag check, payload unpacking, summary
// each result is written into the result queue at the edge that accepts its byte
// throughput: one byte accepted every cycle while the result queue has room for two
// a last byte that also completes a payload result makes two results; the result
// queue of four absorbs the extra one; bytes go one a cycle while results drain
// reset: synchronous, clears parser state and empties the result queue
module fm_datagram_parser
   import fmdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fmdp_req_if.sink    req_chan,
   fmdp_rsp_if.source  rsp_chan
);

   // parser state
   phase_type               phase_ff, phase_in;
   pkt_type                 tag_ff, tag_in;
   logic                    prefix_bad_ff, prefix_bad_in;
   logic [7:0]              low_hold_ff, low_hold_in;
   logic                    pair_half_ff, pair_half_in;
   logic [SMP_CNT_W-1:0]    smp_cnt_ff, smp_cnt_in;
   logic [CHAR_CNT_W-1:0]   char_cnt_ff, char_cnt_in;
   logic                    cs_done_ff, cs_done_in;

   // results produced by the current byte
   result_type              pay_res, sum_res;
   logic                    has_pay, has_sum;
   result_type              push_first, push_second;
   logic [1:0]              push_n;

   logic                    accept;
   logic                    room_two;
   logic [CHAR_CNT_W-1:0]   char_next;
   result_type              pop_data;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = room_two;
   assign char_next     = char_cnt_ff + 1'b1;

   // next state and results of one byte
   always_comb begin
      phase_in      = phase_ff;
      tag_in        = tag_ff;
      prefix_bad_in = prefix_bad_ff;
      low_hold_in   = low_hold_ff;
      pair_half_in  = pair_half_ff;
      smp_cnt_in    = smp_cnt_ff;
      char_cnt_in   = char_cnt_ff;
      cs_done_in    = cs_done_ff;
      pay_res       = RESULT_ZERO;
      sum_res       = RESULT_ZERO;
      has_pay       = 1'b0;
      has_sum       = 1'b0;

      case (phase_ff)
         PHASE_TAG0: begin
            if (req_chan.data_byte != CHAR_F) begin
               prefix_bad_in = 1'b1;
            end
            phase_in = PHASE_TAG1;
         end
         PHASE_TAG1: begin
            if (req_chan.data_byte != CHAR_M) begin
               prefix_bad_in = 1'b1;
            end
            phase_in = PHASE_TAG2;
         end
         PHASE_TAG2: begin
            tag_in = PKT_NONE;
            if (!prefix_bad_ff) begin
               case (req_chan.data_byte)
                  CHAR_P:  tag_in = PKT_PING;
                  CHAR_E:  tag_in = PKT_END;
                  CHAR_S:  tag_in = PKT_START;
                  CHAR_D:  tag_in = PKT_DATA;
                  default: tag_in = PKT_NONE;
               endcase
            end
            phase_in = PHASE_PAYLOAD;
         end
         default: begin
            // payload bytes: callsign characters or sample pairs
            if (tag_ff == PKT_START && !cs_done_ff) begin
               if (req_chan.data_byte == CHAR_NUL ||
                   char_cnt_ff >= CHAR_CNT_W'(CALLSIGN_BOUND - 1)) begin
                  cs_done_in = 1'b1;
               end else begin
                  has_pay                = 1'b1;
                  pay_res.result_kind    = KIND_CHAR;
                  pay_res.char_value     = req_chan.data_byte;
                  char_cnt_in            = char_next;
                  if (char_next >= CHAR_CNT_W'(CALLSIGN_BOUND - 1)) begin
                     cs_done_in = 1'b1;
                  end
               end
            end else if (tag_ff == PKT_DATA) begin
               if (!pair_half_ff) begin
                  low_hold_in  = req_chan.data_byte;
                  pair_half_in = 1'b1;
               end else begin
                  pair_half_in = 1'b0;
                  if (smp_cnt_ff < SMP_CNT_W'(MAX_SAMPLES)) begin
                     has_pay              = 1'b1;
                     pay_res.result_kind  = KIND_SAMPLE;
                     pay_res.audio_sample = {req_chan.data_byte, low_hold_ff};
                     smp_cnt_in           = smp_cnt_ff + 1'b1;
                  end
               end
            end
         end
      endcase

      // summary on the last byte, then back to the start of a datagram
      if (req_chan.last_byte) begin
         has_sum             = 1'b1;
         sum_res.result_kind = KIND_SUMMARY;
         if (phase_in != PHASE_PAYLOAD) begin
            // fewer than three bytes
            sum_res.malformed = 1'b1;
         end else begin
            sum_res.packet_type    = tag_in;
            sum_res.malformed      = prefix_bad_in;
            sum_res.sample_total   = SMP_TOT_W'(smp_cnt_in);
            sum_res.callsign_total = CHAR_TOT_W'(char_cnt_in);
         end
         phase_in      = PHASE_TAG0;
         tag_in        = PKT_NONE;
         prefix_bad_in = 1'b0;
         low_hold_in   = 8'd0;
         pair_half_in  = 1'b0;
         smp_cnt_in    = '0;
         char_cnt_in   = '0;
         cs_done_in    = 1'b0;
      end

      // run_last marks the final result of this byte
      if (has_sum) begin
         sum_res.run_last = 1'b1;
      end else begin
         pay_res.run_last = 1'b1;
      end

      push_first  = has_pay ? pay_res : sum_res;
      push_second = sum_res;
      if (!accept) begin
         push_n = 2'd0;
      end else begin
         push_n = {1'b0, has_pay} + {1'b0, has_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_TAG0;
         tag_ff        <= PKT_NONE;
         prefix_bad_ff <= 1'b0;
         low_hold_ff   <= 8'd0;
         pair_half_ff  <= 1'b0;
         smp_cnt_ff    <= '0;
         char_cnt_ff   <= '0;
         cs_done_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tag_ff        <= tag_in;
         prefix_bad_ff <= prefix_bad_in;
         low_hold_ff   <= low_hold_in;
         pair_half_ff  <= pair_half_in;
         smp_cnt_ff    <= smp_cnt_in;
         char_cnt_ff   <= char_cnt_in;
         cs_done_ff    <= cs_done_in;
      end
   end

   // result queue decouples the byte side from the result side
   fmdp_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_n      (push_n),
      .push_first  (push_first),
      .push_second (push_second),
      .room_two    (room_two),
      .pop_valid   (rsp_chan.valid),
      .pop_ready   (rsp_chan.ready),
      .pop_data    (pop_data)
   );

   assign rsp_chan.result_kind    = pop_data.result_kind;
   assign rsp_chan.char_value     = pop_data.char_value;
   assign rsp_chan.audio_sample   = pop_data.audio_sample;
   assign rsp_chan.packet_type    = pop_data.packet_type;
   assign rsp_chan.malformed      = pop_data.malformed;
   assign rsp_chan.sample_total   = pop_data.sample_total;
   assign rsp_chan.callsign_total = pop_data.callsign_total;
   assign rsp_chan.run_last       = pop_data.run_last;

   // a last byte always returns the parser to the first tag byte
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_byte |=> phase_ff == PHASE_TAG0 && smp_cnt_ff == '0)
      else $error("parser did not restart after last byte");

   // a malformed summary never carries a packet type
   a_malformed_untyped: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && pop_data.result_kind == KIND_SUMMARY && pop_data.malformed
      |-> pop_data.packet_type == PKT_NONE)
      else $error("malformed summary with a packet type");

   // counts stay within their limits
   a_count_limits: assert property (@(posedge clock) disable iff (reset)
      smp_cnt_ff <= SMP_CNT_W'(MAX_SAMPLES) &&
      char_cnt_ff <= CHAR_CNT_W'(CALLSIGN_BOUND - 1))
      else $error("count beyond its limit");

   // payload state only changes once the tag is complete
   a_tag_before_payload: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PHASE_PAYLOAD |-> !pair_half_ff && char_cnt_ff == '0)
      else $error("payload state set before the tag");

endmodule

@@ sv/fmdp_result_fifo.sv @@
// small result queue taking up to two results per cycle and giving one
module fmdp_result_fifo
   import fmdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_n,
   input  result_type push_first,
   input  result_type push_second,
   output logic       room_two,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data
);

   result_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;
   logic [FIFO_PTR_W-1:0]   wr_next;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_next] <= push_second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

endmodule

@@ sim/fmdp_result_checker.sv @@
`timescale 1ns / 100ps
// result checker of the fm datagram parser: predicts results from accepted bytes and compares them
module fmdp_result_checker
   import fmdp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fmdp_req_if  req_mon,
   fmdp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_pending,
   output int   bytes_seen,
   output int   frames_seen,
   output int   chars_seen,
   output int   samples_seen,
   output int   malformed_seen,
   output int   limit_hits
);

   // parser state as predicted from the byte stream
   phase_type             phase;
   pkt_type               tag;
   logic                  prefix_bad;
   logic [7:0]            low_hold;
   logic                  pair_half;
   logic [SMP_CNT_W-1:0]  sample_count;
   logic [CHAR_CNT_W-1:0] char_count;
   logic                  callsign_done;

   result_type expected_results[$];

   task automatic clear_parse_state();
      phase         = PHASE_TAG0;
      tag           = PKT_NONE;
      prefix_bad    = 1'b0;
      low_hold      = '0;
      pair_half     = 1'b0;
      sample_count  = '0;
      char_count    = '0;
      callsign_done = 1'b0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      result_type made[2];
      int         n;
      int         i;
      n       = 0;
      made[0] = RESULT_ZERO;
      made[1] = RESULT_ZERO;
      case (phase)
         PHASE_TAG0: begin
            if (b != CHAR_F) prefix_bad = 1'b1;
            phase = PHASE_TAG1;
         end
         PHASE_TAG1: begin
            if (b != CHAR_M) prefix_bad = 1'b1;
            phase = PHASE_TAG2;
         end
         PHASE_TAG2: begin
            tag = PKT_NONE;
            if (!prefix_bad) begin
               case (b)
                  CHAR_P:  tag = PKT_PING;
                  CHAR_E:  tag = PKT_END;
                  CHAR_S:  tag = PKT_START;
                  CHAR_D:  tag = PKT_DATA;
                  default: tag = PKT_NONE;
               endcase
            end
            phase = PHASE_PAYLOAD;
         end
         default: begin
            if (tag == PKT_START && !callsign_done) begin
               if (b == CHAR_NUL || char_count >= CALLSIGN_BOUND - 1) begin
                  callsign_done = 1'b1;
               end else begin
                  made[n].result_kind = KIND_CHAR;
                  made[n].char_value  = b;
                  n++;
                  char_count++;
                  if (char_count >= CALLSIGN_BOUND - 1) callsign_done = 1'b1;
               end
            end else if (tag == PKT_DATA) begin
               if (!pair_half) begin
                  low_hold  = b;
                  pair_half = 1'b1;
               end else begin
                  pair_half = 1'b0;
                  if (sample_count < MAX_SAMPLES) begin
                     made[n].result_kind  = KIND_SAMPLE;
                     made[n].audio_sample = {b, low_hold};
                     n++;
                     sample_count++;
                  end
               end
            end
         end
      endcase
      if (last) begin
         made[n].result_kind = KIND_SUMMARY;
         // fewer than three bytes: no type, no counts
         if (phase != PHASE_PAYLOAD) begin
            made[n].malformed = 1'b1;
         end else begin
            made[n].packet_type    = tag;
            made[n].malformed      = prefix_bad;
            made[n].sample_total   = sample_count;
            made[n].callsign_total = char_count;
         end
         n++;
         clear_parse_state();
      end
      if (n > 0) made[n-1].run_last = 1'b1;
      for (i = 0; i < n; i++) expected_results.push_back(made[i]);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         clear_parse_state();
         expected_results.delete();
         mismatch_count = 0;
         bytes_seen     = 0;
         frames_seen    = 0;
         chars_seen     = 0;
         samples_seen   = 0;
         malformed_seen = 0;
         limit_hits     = 0;
      end else begin
         // results first: a byte taken at this edge cannot have its result here yet
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.result_kind    = kind_type'(rsp_mon.result_kind);
            got.char_value     = rsp_mon.char_value;
            got.audio_sample   = rsp_mon.audio_sample;
            got.packet_type    = pkt_type'(rsp_mon.packet_type);
            got.malformed      = rsp_mon.malformed;
            got.sample_total   = rsp_mon.sample_total;
            got.callsign_total = rsp_mon.callsign_total;
            got.run_last       = rsp_mon.run_last;
            if (expected_results.size() == 0) begin
               $error("result of kind %0d arrived with nothing expected", got.result_kind);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", want.result_kind, got.result_kind);
               check_field("char_value", want.char_value, got.char_value);
               check_field("audio_sample", longint'($signed(want.audio_sample)),
                           longint'($signed(got.audio_sample)));
               check_field("packet_type", want.packet_type, got.packet_type);
               check_field("malformed", want.malformed, got.malformed);
               check_field("sample_total", want.sample_total, got.sample_total);
               check_field("callsign_total", want.callsign_total, got.callsign_total);
               check_field("run_last", want.run_last, got.run_last);
            end
            case (got.result_kind)
               KIND_CHAR:   chars_seen++;
               KIND_SAMPLE: samples_seen++;
               default: begin
                  frames_seen++;
                  if (got.malformed) malformed_seen++;
                  if (got.sample_total == MAX_SAMPLES ||
                      got.callsign_total == CALLSIGN_BOUND - 1)
                     limit_hits++;
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            bytes_seen++;
            parse_byte(req_mon.data_byte, req_mon.last_byte);
         end
      end
      results_pending = expected_results.size();
   end

endmodule

@@ sim/tb_fm_datagram_parser.sv @@
`timescale 1ns / 100ps
// testbench top of the fm datagram parser: stimulus, back-pressure and verdict
module tb_fm_datagram_parser
   import fmdp_pkg::*;
();

   // random part length in bytes, and the long receiver hold-off in cycles
   localparam int RANDOM_BYTES    = 1900;
   localparam int HOLD_OFF_CYCLES = 300;
   // odd payload past the sample limit: 260 pairs plus a trailing byte
   localparam int LONG_PAYLOAD    = 2 * MAX_SAMPLES + 9;
   // after the expected results, the drain wait catches stray extra results
   localparam int DRAIN_CYCLES    = 8;

   logic clock = 1'b0;
   logic reset;

   fmdp_req_if req_if ();
   fmdp_rsp_if rsp_if ();

   int mismatch_count;
   int results_pending;
   int bytes_seen;
   int frames_seen;
   int chars_seen;
   int samples_seen;
   int malformed_seen;
   int limit_hits;

   // datagram under construction, sent byte by byte
   logic [7:0] frame[$];
   int         burst_left    = 0;
   int         random_bytes  = 0;
   logic       hold_off_request = 1'b0;
   int         hold_offs_done   = 0;

   fm_datagram_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   fmdp_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .bytes_seen      (bytes_seen),
      .frames_seen     (frames_seen),
      .chars_seen      (chars_seen),
      .samples_seen    (samples_seen),
      .malformed_seen  (malformed_seen),
      .limit_hits      (limit_hits)
   );

   always #1 clock = ~clock;

   // offer one byte and hold it until the transaction completes; between bursts the
   // sender drops valid for a random gap, sometimes for none at all
   task automatic offer_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // the last byte of the frame carries the end flag
   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++) offer_byte(frame[i], i == frame.size() - 1);
   endtask

   // mostly well-formed datagrams with random payload, plus short ones and bad prefixes
   task automatic build_random_frame();
      int         pick;
      int         len;
      int         i;
      logic [7:0] tag_byte;
      frame.delete();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // short datagram: one or two bytes, often a plausible start
         frame.push_back($urandom_range(0, 1) ? CHAR_F : 8'($urandom));
         if ($urandom_range(0, 1)) frame.push_back($urandom_range(0, 1) ? CHAR_M : 8'($urandom));
         return;
      end
      if (pick < 26) begin
         // bad prefix: first, second or both bytes corrupted
         case ($urandom_range(0, 2))
            0: begin
               frame.push_back(8'($urandom));
               frame.push_back(CHAR_M);
            end
            1: begin
               frame.push_back(CHAR_F);
               frame.push_back(8'($urandom));
            end
            default: begin
               frame.push_back(8'($urandom));
               frame.push_back(8'($urandom));
            end
         endcase
      end else begin
         frame.push_back(CHAR_F);
         frame.push_back(CHAR_M);
      end
      case ($urandom_range(0, 9))
         0:       tag_byte = CHAR_P;
         1:       tag_byte = CHAR_E;
         2, 3, 4: tag_byte = CHAR_S;
         5, 6, 7: tag_byte = CHAR_D;
         default: tag_byte = 8'($urandom);   // almost always an unknown tag
      endcase
      frame.push_back(tag_byte);
      if (tag_byte == CHAR_S) begin
         // callsign, at times past the bound, then maybe a nul and trailing junk
         len = $urandom_range(0, 20);
         for (i = 0; i < len; i++) frame.push_back(8'($urandom_range(1, 255)));
         if ($urandom_range(0, 1)) begin
            frame.push_back(CHAR_NUL);
            len = $urandom_range(0, 3);
            for (i = 0; i < len; i++) frame.push_back(8'($urandom));
         end
      end else if (tag_byte == CHAR_D) begin
         // odd and even lengths both occur, so trailing bytes get exercised
         len = $urandom_range(0, 25);
         for (i = 0; i < len; i++) frame.push_back(8'($urandom));
      end else begin
         len = $urandom_range(0, 4);
         for (i = 0; i < len; i++) frame.push_back(8'($urandom));
      end
   endtask

   // receiver: ready pattern changes mode every so often, from never stalling to
   // rarely ready; on request it holds off for a long stretch so the result queue
   // fills and the block has to stall its byte input
   initial begin
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_offs_done++;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic long_sent;
      logic second_hold;
      long_sent   = 1'b0;
      second_hold = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed datagrams
      // single byte, then two bytes: both too short to carry a tag
      frame = {CHAR_F};
      send_frame();
      frame = {CHAR_F, CHAR_M};
      send_frame();
      // ping with nothing after the tag
      frame = {CHAR_F, CHAR_M, CHAR_P};
      send_frame();
      // end carrying a payload byte that must be ignored
      frame = {CHAR_F, CHAR_M, CHAR_E, 8'hFF};
      send_frame();
      // bad prefix in front of a data tag
      frame = {CHAR_NUL, CHAR_M, CHAR_D};
      send_frame();
      // start: one character, nul ends the callsign, later byte ignored
      frame = {CHAR_F, CHAR_M, CHAR_S, 8'h41, CHAR_NUL, 8'h42};
      send_frame();
      // data: most negative and most positive samples, then an odd trailing byte
      frame = {CHAR_F, CHAR_M, CHAR_D, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01};
      send_frame();

      // random datagrams, with a long hold-off at the start and one midway
      hold_off_request = 1'b1;
      while (random_bytes < RANDOM_BYTES) begin
         if (!long_sent && random_bytes > 800) begin
            // one data datagram that runs past the sample limit
            frame = {CHAR_F, CHAR_M, CHAR_D};
            repeat (LONG_PAYLOAD) frame.push_back(8'($urandom));
            long_sent = 1'b1;
         end else begin
            build_random_frame();
         end
         if (!second_hold && random_bytes > 1200) begin
            hold_off_request = 1'b1;
            second_hold      = 1'b1;
         end
         send_frame();
         random_bytes += frame.size();
      end
      req_if.valid <= 1'b0;

      // drain: let the checker see the final byte, wait for every expected
      // result, then the drain wait for anything extra
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d datagrams: %0d callsign characters, %0d samples",
               bytes_seen, frames_seen, chars_seen, samples_seen);
      $display("%0d malformed datagrams, %0d at a count limit, %0d long receiver hold-offs",
               malformed_seen, limit_hits, hold_offs_done);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
